[rtl/mrfb_pkg.sv]
// Package for the Modbus register frame builder.
// Holds the queued item type, frame constants and the CRC-16 byte update.
// No dependencies.
package mrfb_pkg;

  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned FRAME_LEN = 21;
  localparam int unsigned CRC_SPAN  = 19;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_CODE  = 8'h10;
  localparam logic [7:0] START_HI   = 8'h00;
  localparam logic [7:0] START_LO   = 8'h01;
  localparam logic [7:0] QTY_HI     = 8'h00;
  localparam logic [7:0] QTY_LO     = 8'h06;
  localparam logic [7:0] BYTE_COUNT = 8'd12;

  localparam logic [IDX_W-1:0] IDX_ADDR    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_FUNC    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_STHI    = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_STLO    = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_QTHI    = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_QTLO    = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_BCNT    = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_DATA0   = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_CRC_LO  = IDX_W'(CRC_SPAN);
  localparam logic [IDX_W-1:0] IDX_CRC_HI  = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [NUM_REGS-1:0][15:0] regs;
    logic [7:0]                station;
  } mrfb_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_byte(input mrfb_item_t item,
                                            input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] off;
    logic [15:0]      word;
    off  = idx - IDX_DATA0;
    word = (off[IDX_W-1:1] < (IDX_W-1)'(NUM_REGS)) ? item.regs[off[3:1]] : 16'h0000;
    case (idx)
      IDX_ADDR: frame_byte = item.station;
      IDX_FUNC: frame_byte = FUNC_CODE;
      IDX_STHI: frame_byte = START_HI;
      IDX_STLO: frame_byte = START_LO;
      IDX_QTHI: frame_byte = QTY_HI;
      IDX_QTLO: frame_byte = QTY_LO;
      IDX_BCNT: frame_byte = BYTE_COUNT;
      default:  frame_byte = off[0] ? word[7:0] : word[15:8];
    endcase
  endfunction

endpackage

[rtl/mrfb_front.sv]
// Front end: station address register and the item queue.
// Tags each accepted word with the current address. Depends on mrfb_pkg.
module mrfb_front import mrfb_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [NUM_REGS*16-1:0] in_data_i,
  output logic        head_valid_o,
  output mrfb_item_t  head_o,
  input  logic        pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       station_q, station_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  mrfb_item_t       entry_q [DEPTH];
  logic             push, pop;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (count_q != CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    station_d = cfg_valid_i ? cfg_data_i : station_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    count_d   = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= 8'd1;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      count_q   <= '0;
    end else begin
      station_q <= station_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{regs: in_data_i, station: station_q};
    end
  end

endmodule

[rtl/mrfb_back.sv]
// Back end: walks the queue head byte by byte, folds the CRC and drives
// the registered output byte. Depends on mrfb_pkg.
module mrfb_back import mrfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  mrfb_item_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             load;

  assign load        = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o       = load && (idx_q == IDX_CRC_HI);
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_comb begin
    idx_d   = idx_q;
    crc_d   = crc_q;
    valid_d = valid_q && !out_ready_i;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      last_d  = (idx_q == IDX_CRC_HI);
      if (idx_q == IDX_CRC_HI) begin
        byte_d = crc_q[15:8];
        crc_d  = CRC_INIT;
        idx_d  = '0;
      end else if (idx_q == IDX_CRC_LO) begin
        byte_d = crc_q[7:0];
        idx_d  = idx_q + 1'b1;
      end else begin
        byte_d = frame_byte(head_i, idx_q);
        crc_d  = crc_byte(crc_q, byte_d);
        idx_d  = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      crc_q   <= CRC_INIT;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

endmodule

[rtl/modbus_register_frame_builder_top.sv]
// Modbus RTU frame builder: six 16-bit values in, 21 framed bytes out.
// An accepted input word is written to the queue; its first byte then goes out through the back end's output register.
// The back end sends one byte per cycle while an item is queued and m_axis_tready is high.
// The queue of QUEUE_DEPTH items lets input words land while a frame drains.
// Reset (rst_ni low, asynchronous): queue empty, output idle, address 1.
// Depends on mrfb_pkg, mrfb_front and mrfb_back.
module modbus_register_frame_builder_top import mrfb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // station_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ref ohms, pot ohms, mV, uA, uW, uW*s
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_byte
  output logic        m_axis_tlast    // last_byte
);

  mrfb_item_t head;
  logic       head_valid;
  logic       pop;

  mrfb_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  mrfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

[rtl/mrfb_checker.sv]
// Port-level checker for the frame builder, bound to the top level.
// Tracks byte position and frames owed from the ports alone.
module mrfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [4:0] pos_q;
  logic [7:0] owed_q;
  logic       in_acc, out_acc, out_end;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign out_end = out_acc && m_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      owed_q <= '0;
    end else begin
      if (out_acc) begin
        pos_q <= (pos_q == 5'd20) ? 5'd0 : pos_q + 5'd1;
      end
      owed_q <= owed_q + {7'd0, in_acc} - {7'd0, out_end};
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (m_axis_tlast == (pos_q == 5'd20)))
    else $error("tlast not on byte 21 of frame");

  a_func_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (pos_q == 5'd1) |-> (m_axis_tdata == 8'h10))
    else $error("second frame byte is not the function code");

  a_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (owed_q != 8'd0))
    else $error("output word with no accepted item behind it");

endmodule

bind modbus_register_frame_builder_top mrfb_checker u_mrfb_checker (.*);
